// ===== hdl/mwg_pkg.sv =====
// ----------------------------------------------------------------------------
// mwg_pkg
// Shared constants, types and the quarter-wave sine table of the waveform
// generator.
// ----------------------------------------------------------------------------
`default_nettype none

package mwg_pkg;

  localparam int PhaseBits     = 32;
  localparam int TableAddrBits = 8;
  localparam int CountBits     = 24;
  localparam int TableSize     = 1 << TableAddrBits;
  localparam int CfgDataBits   = 32;
  localparam int CfgIdxBits    = 2;

  localparam int SampleBits    = 16;
  localparam int AmpBits       = 15;
  localparam int PointBits     = 15;
  localparam int UnitBits      = 17;
  localparam int ProdBits      = 32;
  localparam int MagBits       = 17;

  localparam logic [AmpBits-1:0]   AmpReset   = 15'd32767;
  localparam logic [CountBits-1:0] CountReset = CountBits'(8000);

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;
  localparam longint unsigned Q30One    = 64'd1 << 30;

  typedef logic [PhaseBits-1:0] phase_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [AmpBits-1:0]   amp_t;

  typedef enum logic [2:0] {
    WaveSine     = 3'd0,
    WaveCosine   = 3'd1,
    WaveTriangle = 3'd2,
    WaveRamp     = 3'd3,
    WaveSquare   = 3'd4
  } wave_e;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgWaveSelect   = 2'd0,
    CfgPhaseStep    = 2'd1,
    CfgAmplitude    = 2'd2,
    CfgSampleCount  = 2'd3
  } cfg_idx_e;

  typedef logic [PointBits-1:0] sine_rom_t [0:TableSize];

  // quarter sine in q15, taylor series to x^13 evaluated in q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t       rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    for (int k = 0; k <= TableSize; k++) begin
      x  = (longint'(k) * HalfPiQ30) >> TableAddrBits;
      x2 = (x * x) >> 30;
      t  = Q30One;
      t  = Q30One - ((x2 * t) >> 30) / 156;
      t  = Q30One - ((x2 * t) >> 30) / 110;
      t  = Q30One - ((x2 * t) >> 30) / 72;
      t  = Q30One - ((x2 * t) >> 30) / 42;
      t  = Q30One - ((x2 * t) >> 30) / 20;
      t  = Q30One - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      v  = (s * 32767 + (64'd1 << 29)) >> 30;
      if (v > 32767) begin
        v = 32767;
      end
      rom[k] = PointBits'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SineRom = build_sine_rom();

endpackage

`default_nettype wire

// ===== hdl/mwg_in_if.sv =====
// ----------------------------------------------------------------------------
// mwg_in_if
// Tick channel into the waveform generator: valid, ready and the restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwg_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

`default_nettype wire

// ===== hdl/mwg_out_if.sv =====
// ----------------------------------------------------------------------------
// mwg_out_if
// Sample channel out of the waveform generator: valid, ready and the sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwg_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [mwg_pkg::SampleBits-1:0] sample;
  logic                                last;
  logic                                active;

  modport source (output valid, output sample, output last, output active, input ready);
  modport sink   (input valid, input sample, input last, input active, output ready);
endinterface

`default_nettype wire

// ===== hdl/multi_waveform_generator.sv =====
// ----------------------------------------------------------------------------
// multi_waveform_generator
// Phase-accumulator source of sine, cosine, triangle, ramp and square samples.
// ----------------------------------------------------------------------------
// usage
//   in_if carries one tick item per sample, with a restart flag that clears
//   the phase and the sample counter before that tick's sample is formed.
//   out_if returns exactly one item per tick: the signed sample, a flag on
//   the final sample of the run and an active flag; after the run ends the
//   items are all zero until a restart.
//   the cfg port writes wave select, phase step, amplitude and run length;
//   write it only while no tick is in flight.
//   three register stages: the state update, the table read and one multiply,
//   then the final sign and offset; a sample passes through them in that
//   order from the edge that accepts its tick to the output register.
//   one item per cycle unless stalled; only the phase and count adders loop.
//   when the receiver stalls all three stages hold; while an item waits at
//   the output in_if.ready follows out_if.ready, so nothing is lost.
//   reset clears the phase, the counter, the stage valid bits and loads the
//   register defaults (sine, zero step, full amplitude, 8000 samples).
// ----------------------------------------------------------------------------
`default_nettype none

module multi_waveform_generator (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mwg_pkg::CfgIdxBits-1:0]      cfg_idx_i,
  input  wire logic [mwg_pkg::CfgDataBits-1:0]     cfg_data_i,
  mwg_in_if.sink                                   in_if,
  mwg_out_if.source                                out_if
);

  localparam int Tab = mwg_pkg::TableAddrBits;
  localparam int Pb  = mwg_pkg::PhaseBits;

  typedef struct packed {
    mwg_pkg::phase_t phase;
    mwg_pkg::amp_t   amp;
    mwg_pkg::wave_e  wave;
    logic            last;
    logic            active;
  } s1_t;

  typedef struct packed {
    logic [mwg_pkg::MagBits-1:0] mag;
    logic                        neg;
    logic                        sq_neg;
    mwg_pkg::amp_t               amp;
    mwg_pkg::wave_e              wave;
    logic                        last;
    logic                        active;
  } s2_t;

  // configuration registers
  mwg_pkg::wave_e  wave_q;
  mwg_pkg::phase_t step_q;
  mwg_pkg::amp_t   amp_q;
  mwg_pkg::count_t len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q <= mwg_pkg::WaveSine;
      step_q <= '0;
      amp_q  <= mwg_pkg::AmpReset;
      len_q  <= mwg_pkg::CountReset;
    end else if (cfg_we_i) begin
      case (mwg_pkg::cfg_idx_e'(cfg_idx_i))
        mwg_pkg::CfgWaveSelect:  wave_q <= mwg_pkg::wave_e'(cfg_data_i[2:0]);
        mwg_pkg::CfgPhaseStep:   step_q <= Pb'(cfg_data_i);
        mwg_pkg::CfgAmplitude:   amp_q  <= cfg_data_i[mwg_pkg::AmpBits-1:0];
        mwg_pkg::CfgSampleCount: len_q  <= cfg_data_i[mwg_pkg::CountBits-1:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic en, accept;

  assign en          = !out_valid_q || out_if.ready;
  assign accept      = in_if.valid && en;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_if.valid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // phase and run state
  mwg_pkg::phase_t phase_q, phase_d, phase_cur;
  mwg_pkg::count_t done_q, done_d, done_cur, done_inc;
  logic            run_on;
  s1_t             s1_d, s1_q;

  always_comb begin
    phase_cur = in_if.restart ? '0 : phase_q;
    done_cur  = in_if.restart ? '0 : done_q;
    done_inc  = done_cur + mwg_pkg::count_t'(1);
    run_on    = done_cur < len_q;
    phase_d   = phase_cur;
    done_d    = done_cur;
    if (run_on) begin
      phase_d = phase_cur + step_q;
      done_d  = done_inc;
    end
    s1_d.phase  = phase_cur;
    s1_d.amp    = amp_q;
    s1_d.wave   = wave_q;
    s1_d.last   = run_on && (done_inc == len_q);
    s1_d.active = run_on;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      done_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
    end
  end

  // table read and amplitude multiply
  logic [Tab+1:0]                  u;
  logic [1:0]                      quad;
  logic [Tab:0]                    kk;
  logic [mwg_pkg::PointBits-1:0]   pt;
  logic [15:0]                     w;
  logic [16:0]                     tri_diff;
  logic [mwg_pkg::UnitBits-1:0]    op;
  logic [mwg_pkg::ProdBits-1:0]    prod;
  s2_t                             s2_d, s2_q;

  always_comb begin
    u        = s1_q.phase[Pb-1 -: Tab+2];
    quad     = u[Tab+1:Tab] + {1'b0, (s1_q.wave == mwg_pkg::WaveCosine)};
    kk       = quad[0] ? ((Tab+1)'(mwg_pkg::TableSize) - {1'b0, u[Tab-1:0]})
                       : {1'b0, u[Tab-1:0]};
    pt       = mwg_pkg::SineRom[kk];
    w        = s1_q.phase[Pb-1 -: 16];
    tri_diff = 17'h10000 - {1'b0, w};
    case (s1_q.wave)
      mwg_pkg::WaveSine,
      mwg_pkg::WaveCosine:   op = {2'b00, pt};
      mwg_pkg::WaveTriangle: op = w[15] ? {tri_diff[15:0], 1'b0} : {w, 1'b0};
      mwg_pkg::WaveRamp:     op = {1'b0, w};
      default:               op = '0;
    endcase
    prod        = mwg_pkg::ProdBits'(s1_q.amp) * mwg_pkg::ProdBits'(op);
    s2_d.mag    = mwg_pkg::MagBits'((prod + 32'd16384) >> 15);
    s2_d.neg    = quad[1];
    s2_d.sq_neg = w[15];
    s2_d.amp    = s1_q.amp;
    s2_d.wave   = s1_q.wave;
    s2_d.last   = s1_q.last;
    s2_d.active = s1_q.active;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q <= s2_d;
    end
  end

  // sign and offset
  logic signed [17:0]                   ramp_val;
  logic signed [mwg_pkg::SampleBits-1:0] amp_s;
  logic signed [mwg_pkg::SampleBits-1:0] mag_s;
  logic signed [mwg_pkg::SampleBits-1:0] sample_d, sample_q;
  logic                                 last_q, active_q;

  always_comb begin
    ramp_val = $signed({1'b0, s2_q.mag}) - $signed({3'b000, s2_q.amp});
    amp_s    = $signed({1'b0, s2_q.amp});
    mag_s    = $signed(s2_q.mag[mwg_pkg::SampleBits-1:0]);
    case (s2_q.wave)
      mwg_pkg::WaveSine,
      mwg_pkg::WaveCosine:   sample_d = s2_q.neg ? -mag_s : mag_s;
      mwg_pkg::WaveTriangle,
      mwg_pkg::WaveRamp:     sample_d = ramp_val[mwg_pkg::SampleBits-1:0];
      mwg_pkg::WaveSquare:   sample_d = s2_q.sq_neg ? -amp_s : amp_s;
      default:               sample_d = '0;
    endcase
    if (!s2_q.active) begin
      sample_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sample_q <= sample_d;
      last_q   <= s2_q.last;
      active_q <= s2_q.active;
    end
  end

  assign out_if.valid  = out_valid_q;
  assign out_if.sample = sample_q;
  assign out_if.last   = last_q;
  assign out_if.active = active_q;

endmodule

`default_nettype wire

// ===== hdl/mwg_checker.sv =====
// ----------------------------------------------------------------------------
// mwg_checker
// Port-level checks of the waveform generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mwg_checker (
  input wire logic                                clk_i,
  input wire logic                                rst_ni,
  input wire logic                                in_valid_i,
  input wire logic                                in_ready_i,
  input wire logic                                out_valid_i,
  input wire logic                                out_ready_i,
  input wire logic signed [mwg_pkg::SampleBits-1:0] sample_i,
  input wire logic                                last_i,
  input wire logic                                active_i
);

  // final sample of a run is always a run sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i |-> active_i)
    else $error("last flagged on an inactive item");

  // finished run gives all-zero items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !active_i |-> (sample_i == '0) && !last_i)
    else $error("nonzero item after the run ended");

  // an empty output register never blocks ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("tick refused while output is empty");

  // a stalled item holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(sample_i)
      && $stable(last_i) && $stable(active_i))
    else $error("stalled item changed");

  // a tick accepted against a stalled output cannot happen
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && out_valid_i |-> out_ready_i)
    else $error("tick taken while output stalled");

endmodule

bind multi_waveform_generator mwg_checker u_mwg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_if.valid),
  .in_ready_i  (in_if.ready),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .sample_i    (out_if.sample),
  .last_i      (out_if.last),
  .active_i    (out_if.active)
);

`default_nettype wire
